### src/assert_macros.svh
// Assertion macros shared by the RTL of the deadline-ordered task queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag any clock edge, outside reset, at which expr holds.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("never-condition violated");

// Same-cycle implication: whenever ante holds, cons must hold too.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

### src/dotq_pkg.sv
// Shared types and constants of the deadline-ordered task queue.
`timescale 1ns / 1ps

package dotq_pkg;

	localparam int CAPACITY      = 16;
	localparam int DEADLINE_BITS = 32;
	localparam int CNT_W         = $clog2(CAPACITY + 1);

	localparam int CMD_W      = 2;
	localparam int TID_W      = 8;
	localparam int DL_FIELD_W = 32;
	localparam int STATUS_W   = 2;
	localparam int OCC_W      = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 2'd0,
		CMD_PUSH_HEAD = 2'd1,
		CMD_PUSH_TAIL = 2'd2,
		CMD_POP       = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ACT_HOLD = 2'd0,
		ACT_NEW  = 2'd1,
		ACT_PREV = 2'd2,
		ACT_NEXT = 2'd3
	} cell_act_t;

	typedef struct packed {
		logic      valid;
		cell_act_t act;
	} cell_ctl_t;

endpackage

### src/dotq_cell.sv
// One slot of the queue: holds an entry, compares it, shifts with its neighbours.
`timescale 1ns / 1ps

module dotq_cell (
	input  logic                                  clk,
	input  dotq_pkg::cell_ctl_t                   ctl,
	input  logic [dotq_pkg::DEADLINE_BITS-1:0]    cmp_deadline,
	input  logic [dotq_pkg::DEADLINE_BITS-1:0]    new_deadline,
	input  logic [dotq_pkg::TID_W-1:0]            new_tid,
	input  logic [dotq_pkg::DEADLINE_BITS-1:0]    prev_deadline,
	input  logic [dotq_pkg::TID_W-1:0]            prev_tid,
	input  logic [dotq_pkg::DEADLINE_BITS-1:0]    next_deadline,
	input  logic [dotq_pkg::TID_W-1:0]            next_tid,
	output logic [dotq_pkg::DEADLINE_BITS-1:0]    slot_deadline,
	output logic [dotq_pkg::TID_W-1:0]            slot_tid,
	output logic                                  lt
);

	logic [dotq_pkg::DEADLINE_BITS-1:0] deadline_q;
	logic [dotq_pkg::TID_W-1:0]         tid_q;

	// Payload only: no reset.
	always_ff @(posedge clk) begin
		unique case (ctl.act)
			dotq_pkg::ACT_HOLD: begin
				deadline_q <= deadline_q;
				tid_q      <= tid_q;
			end
			dotq_pkg::ACT_NEW: begin
				deadline_q <= new_deadline;
				tid_q      <= new_tid;
			end
			dotq_pkg::ACT_PREV: begin
				deadline_q <= prev_deadline;
				tid_q      <= prev_tid;
			end
			dotq_pkg::ACT_NEXT: begin
				deadline_q <= next_deadline;
				tid_q      <= next_tid;
			end
			default: begin
				deadline_q <= deadline_q;
				tid_q      <= tid_q;
			end
		endcase
	end

	// Occupied slot whose deadline is strictly earlier than the candidate.
	assign lt            = ctl.valid & (deadline_q < cmp_deadline);
	assign slot_deadline = deadline_q;
	assign slot_tid      = tid_q;

endmodule

### src/deadline_ordered_task_queue_unit.sv
// Top level of the deadline-ordered task queue: control, count and the row of slot cells.
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------------------
//  command  | start in, busy out      | command, task_id, deadline
//  result   | done out (one cycle)    | popped_task_id, popped_deadline, status, occupancy
//
//  The accepting edge latches the command and registers the per-slot ordering
//  decision from the compare in each cell; the next edge shifts the cell row and
//  registers the result. No new command is taken while busy is high, so the row
//  has shifted for one command before the next one is accepted.
//  The result strobe, done, is high for one cycle; the receiver cannot stall.
//  Reset clears the entry count and the control state; slot contents are left
//  as they are and are only ever read below the count.

module deadline_ordered_task_queue_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [dotq_pkg::CMD_W-1:0]          command,
	input  logic [dotq_pkg::TID_W-1:0]          task_id,
	input  logic [dotq_pkg::DL_FIELD_W-1:0]     deadline,
	output logic                                done,
	output logic [dotq_pkg::TID_W-1:0]          popped_task_id,
	output logic [dotq_pkg::DL_FIELD_W-1:0]     popped_deadline,
	output logic [dotq_pkg::STATUS_W-1:0]       status,
	output logic [dotq_pkg::OCC_W-1:0]          occupancy
);

	localparam int CAP = dotq_pkg::CAPACITY;
	localparam int DW  = dotq_pkg::DEADLINE_BITS;
	localparam int CW  = dotq_pkg::CNT_W;

	// Control state.
	logic                     busy_q;
	logic                     done_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_d;

	// Latched transaction.
	dotq_pkg::cmd_t           cmd_s1;
	logic [dotq_pkg::TID_W-1:0] tid_s1;
	logic [DW-1:0]            dl_s1;
	logic [CAP-1:0]           before_s1;

	// Result registers.
	logic [dotq_pkg::TID_W-1:0]      pop_tid_q;
	logic [DW-1:0]                   pop_dl_q;
	dotq_pkg::status_t               status_q;

	logic                     accept;
	logic [DW-1:0]            dl_in;
	logic [CAP-1:0]           slot_valid;
	logic [CAP-1:0]           slot_lt;
	logic [CAP-1:0]           above;
	logic [CAP-1:0]           before_d;
	logic                     q_empty;
	logic                     q_full;
	logic                     do_pop;
	logic                     do_insert;

	logic [DW-1:0]                   cell_dl  [CAP];
	logic [dotq_pkg::TID_W-1:0]      cell_tid [CAP];
	dotq_pkg::cell_ctl_t             cell_ctl [CAP];

	assign accept  = start & ~busy_q;
	assign dl_in   = DW'(deadline);
	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == CW'(CAP));

	// Slot k is occupied when it lies below the count; above[k] says some
	// occupied slot at or behind k holds an earlier deadline, so the new
	// entry lands behind slot k.
	for (genvar k = 0; k < CAP; k++) begin : g_order
		assign slot_valid[k] = (count_q > CW'(k));
		assign above[k]      = |(slot_lt >> k);
	end

	// Decide which slots stay put ahead of the insertion point.
	always_comb begin
		unique case (dotq_pkg::cmd_t'(command))
			dotq_pkg::CMD_INSERT:    before_d = above;
			dotq_pkg::CMD_PUSH_HEAD: before_d = '0;
			dotq_pkg::CMD_PUSH_TAIL: before_d = slot_valid;
			dotq_pkg::CMD_POP:       before_d = '0;
			default:                 before_d = '0;
		endcase
	end

	assign do_pop    = busy_q & (cmd_s1 == dotq_pkg::CMD_POP) & ~q_empty;
	assign do_insert = busy_q & (cmd_s1 != dotq_pkg::CMD_POP) & ~q_full;

	// Per-cell action: drop the head on pop, open a gap on insert.
	for (genvar k = 0; k < CAP; k++) begin : g_ctl
		logic first_free;
		if (k == 0) begin : g_head
			assign first_free = 1'b1;
		end else begin : g_body
			assign first_free = before_s1[k-1];
		end

		always_comb begin
			cell_ctl[k].valid = slot_valid[k];
			priority if (do_pop) begin
				cell_ctl[k].act = dotq_pkg::ACT_NEXT;
			end else if (do_insert && before_s1[k]) begin
				cell_ctl[k].act = dotq_pkg::ACT_HOLD;
			end else if (do_insert && first_free) begin
				cell_ctl[k].act = dotq_pkg::ACT_NEW;
			end else if (do_insert) begin
				cell_ctl[k].act = dotq_pkg::ACT_PREV;
			end else begin
				cell_ctl[k].act = dotq_pkg::ACT_HOLD;
			end
		end
	end

	// The row of cells; the ends reuse their own contents as neighbours.
	for (genvar k = 0; k < CAP; k++) begin : g_cell
		logic [DW-1:0]              prev_dl;
		logic [dotq_pkg::TID_W-1:0] prev_tid;
		logic [DW-1:0]              next_dl;
		logic [dotq_pkg::TID_W-1:0] next_tid;

		if (k == 0) begin : g_first
			assign prev_dl  = cell_dl[k];
			assign prev_tid = cell_tid[k];
		end else begin : g_mid_prev
			assign prev_dl  = cell_dl[k-1];
			assign prev_tid = cell_tid[k-1];
		end

		if (k == CAP - 1) begin : g_last
			assign next_dl  = cell_dl[k];
			assign next_tid = cell_tid[k];
		end else begin : g_mid_next
			assign next_dl  = cell_dl[k+1];
			assign next_tid = cell_tid[k+1];
		end

		dotq_cell u_cell (
			.clk           (clk),
			.ctl           (cell_ctl[k]),
			.cmp_deadline  (dl_in),
			.new_deadline  (dl_s1),
			.new_tid       (tid_s1),
			.prev_deadline (prev_dl),
			.prev_tid      (prev_tid),
			.next_deadline (next_dl),
			.next_tid      (next_tid),
			.slot_deadline (cell_dl[k]),
			.slot_tid      (cell_tid[k]),
			.lt            (slot_lt[k])
		);
	end

	// Entry count after the latched command.
	always_comb begin
		priority if (do_pop) begin
			count_d = count_q - CW'(1);
		end else if (do_insert) begin
			count_d = count_q + CW'(1);
		end else begin
			count_d = count_q;
		end
	end

	// Latch the transaction and the ordering decision on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= dotq_pkg::cmd_t'(command);
			tid_s1    <= task_id;
			dl_s1     <= dl_in;
			before_s1 <= before_d;
		end
	end

	// Control: busy for the cycle after acceptance, strobe the result next.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q  <= accept;
			done_q  <= busy_q;
			count_q <= count_d;
		end
	end

	// Result payload: popped entry or zeros, plus status.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (do_pop) begin
				pop_tid_q <= cell_tid[0];
				pop_dl_q  <= cell_dl[0];
			end else begin
				pop_tid_q <= '0;
				pop_dl_q  <= '0;
			end
			priority if (cmd_s1 == dotq_pkg::CMD_POP && q_empty) begin
				status_q <= dotq_pkg::ST_EMPTY;
			end else if (cmd_s1 != dotq_pkg::CMD_POP && q_full) begin
				status_q <= dotq_pkg::ST_FULL;
			end else begin
				status_q <= dotq_pkg::ST_DONE;
			end
		end
	end

	assign busy            = busy_q;
	assign done            = done_q;
	assign popped_task_id  = pop_tid_q;
	assign popped_deadline = dotq_pkg::DL_FIELD_W'(pop_dl_q);
	assign status          = status_q;
	assign occupancy       = dotq_pkg::OCC_W'(count_q);

	// Checks on the sequencing and on the count.
	`ASSERT_NEVER(a_busy_and_done, clk, arst_n, busy_q && done_q)
	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CW'(CAP))
	`ASSERT_NEXT(a_accept_then_busy, clk, arst_n, accept, busy_q && !done_q)
	`ASSERT_IMPLIES(a_empty_status, clk, arst_n, done_q && status_q == dotq_pkg::ST_EMPTY, count_q == '0)
	`ASSERT_IMPLIES(a_full_status, clk, arst_n, done_q && status_q == dotq_pkg::ST_FULL, count_q == CW'(CAP))

endmodule
